@@ rtl/core/sus_pkg.sv @@
`default_nettype none

package sus_pkg;

  // widths of the item fields
  localparam int unsigned NOW_W = 48;
  localparam int unsigned RD_W = 16;
  localparam int unsigned DL_W = 49;
  localparam int unsigned RETEST_FIELDS = 4;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 8;
  localparam logic [CFG_ADDR_W-1:0] REG_CAT_THRESHOLD = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LOW_THRESHOLD = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RECOVER_MS = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_LOW_HOLD_MS = 8'd3;

  // register reset values
  localparam logic [RD_W-1:0] RECOVER_MS_RST = 16'd250;
  localparam logic [RD_W-1:0] LOW_HOLD_MS_RST = 16'd1000;

  // packed stream widths
  localparam int unsigned IN_TDATA_W = 152;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef logic [RD_W-1:0] sample_t;

  // what one retest lane found
  typedef struct packed {
    logic    hit;
    sample_t sample;
  } lane_res_t;

endpackage

`default_nettype wire

@@ rtl/core/supply_undervoltage_supervisor.sv @@
`default_nettype none

// Undervoltage supervisor for a 5V supply. Each in_ transfer is one periodic
// check: in_tdata holds, from bit 0 up, now_ms[47:0], reading[63:48],
// avg_reading[79:64], device_attached[80], retest_a..retest_d[144:81] and zero
// fill to 152 bits. A low reading is retested by parallel compare lanes, one
// per retest sample, and replaced by the first sample above cat_threshold.
// The block then drops the LED drivers and pulses force_gcr_min on a
// catastrophic reading, cuts the extra port when the drivers are already off
// or when the averaged reading has been low for longer than low_hold_ms, and
// brings the drivers back once recover_ms has passed. Every check yields one
// out_ transfer in the cycle after it was taken; a new check is taken every
// cycle, limited only by the single output register and out_tready. Config
// registers (0 cat_threshold, 1 low_threshold, 2 recover_ms, 3 low_hold_ms) must
// be written through cfg_ while no check is in flight; the block itself does not
// enforce this. cfg_ready is always high and writes to other indexes are dropped.
module supply_undervoltage_supervisor #(
  parameter int unsigned SPIKE_TESTS = 4
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  // now_ms, reading, avg_reading, device_attached, retest_a..retest_d, zero fill
  input  wire  [sus_pkg::IN_TDATA_W-1:0]          in_tdata,
  input  wire                                     in_tvalid,
  output logic                                    in_tready,
  // catastrophic, led_drivers_on, disable_port, force_gcr_min,
  // settled_reading, zero fill
  output logic [sus_pkg::OUT_TDATA_W-1:0]         out_tdata,
  output logic                                    out_tvalid,
  input  wire                                     out_tready,
  input  wire                                     cfg_valid,
  output logic                                    cfg_ready,
  input  wire  [sus_pkg::CFG_ADDR_W-1:0]          cfg_addr,
  input  wire  [sus_pkg::RD_W-1:0]                cfg_data
);

  localparam int unsigned LANES =
    (SPIKE_TESTS > sus_pkg::RETEST_FIELDS) ? sus_pkg::RETEST_FIELDS : SPIKE_TESTS;

  // config registers
  sus_pkg::sample_t cat_threshold_r;
  sus_pkg::sample_t low_threshold_r;
  logic [sus_pkg::RD_W-1:0] recover_ms_r;
  logic [sus_pkg::RD_W-1:0] low_hold_ms_r;

  // supervisor state
  logic leds_enabled_r, leds_enabled_nxt;
  logic recovery_active_r, recovery_active_nxt;
  logic [sus_pkg::DL_W-1:0] recovery_deadline_r, recovery_deadline_nxt;
  logic low_active_r, low_active_nxt;
  logic [sus_pkg::DL_W-1:0] low_deadline_r, low_deadline_nxt;

  // output register
  logic out_valid_r;
  logic [sus_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // unpacked input fields
  logic [sus_pkg::NOW_W-1:0] now_ms;
  sus_pkg::sample_t reading;
  sus_pkg::sample_t avg_reading;
  logic device_attached;
  sus_pkg::sample_t retest [sus_pkg::RETEST_FIELDS];

  sus_pkg::lane_res_t lane_res [LANES];
  sus_pkg::sample_t settled;
  logic cat_now;

  logic in_xfer;
  logic [sus_pkg::DL_W-1:0] now_ext;
  logic trip, dis_cat, attached_eff, low_cond, low_expire, rec_expire;
  logic cat_out, dis, gcr;

  always_comb begin
    now_ms          = in_tdata[47:0];
    reading         = in_tdata[63:48];
    avg_reading     = in_tdata[79:64];
    device_attached = in_tdata[80];
    for (int i = 0; i < sus_pkg::RETEST_FIELDS; i++) begin
      retest[i] = in_tdata[81 + 16*i +: 16];
    end
  end

  // retest compare lanes
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    sus_lane u_lane (
      .sample        (retest[g]),
      .cat_threshold (cat_threshold_r),
      .res           (lane_res[g])
    );
  end

  // pick the first clearing sample
  sus_merge #(
    .LANES (LANES)
  ) u_merge (
    .reading       (reading),
    .cat_threshold (cat_threshold_r),
    .lane_res      (lane_res),
    .settled       (settled),
    .cat_now       (cat_now)
  );

  // handshakes
  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // supervisor decisions for the current check
  always_comb begin
    now_ext      = {1'b0, now_ms};
    trip         = cat_now && leds_enabled_r;
    dis_cat      = cat_now && !leds_enabled_r && device_attached;
    attached_eff = device_attached && !dis_cat;
    low_cond     = (avg_reading < low_threshold_r) && attached_eff;
    // a deadline armed in this check cannot pass in the same check
    low_expire   = low_cond && low_active_r && (now_ext > low_deadline_r);
    rec_expire   = recovery_active_r && (now_ext > recovery_deadline_r);

    low_active_nxt   = low_cond && !low_expire;
    low_deadline_nxt = low_deadline_r;
    if (low_cond && !low_active_r) begin
      low_deadline_nxt = now_ext + {{(sus_pkg::DL_W-sus_pkg::RD_W){1'b0}}, low_hold_ms_r};
    end

    leds_enabled_nxt      = leds_enabled_r;
    recovery_active_nxt   = recovery_active_r;
    recovery_deadline_nxt = recovery_deadline_r;
    cat_out               = 1'b0;
    if (trip) begin
      leds_enabled_nxt      = 1'b0;
      recovery_active_nxt   = 1'b1;
      recovery_deadline_nxt =
        now_ext + {{(sus_pkg::DL_W-sus_pkg::RD_W){1'b0}}, recover_ms_r};
      cat_out               = 1'b1;
    end else if (recovery_active_r) begin
      if (rec_expire) begin
        leds_enabled_nxt    = 1'b1;
        recovery_active_nxt = 1'b0;
      end else begin
        cat_out = 1'b1;
      end
    end

    dis = dis_cat || low_expire;
    gcr = trip;
    out_data_nxt = {4'b0, settled, gcr, dis, leds_enabled_nxt, cat_out};
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cat_threshold_r <= '0;
      low_threshold_r <= '0;
      recover_ms_r    <= sus_pkg::RECOVER_MS_RST;
      low_hold_ms_r   <= sus_pkg::LOW_HOLD_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        sus_pkg::REG_CAT_THRESHOLD: cat_threshold_r <= cfg_data;
        sus_pkg::REG_LOW_THRESHOLD: low_threshold_r <= cfg_data;
        sus_pkg::REG_RECOVER_MS:    recover_ms_r    <= cfg_data;
        sus_pkg::REG_LOW_HOLD_MS:   low_hold_ms_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // state update on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leds_enabled_r      <= 1'b1;
      recovery_active_r   <= 1'b0;
      recovery_deadline_r <= '0;
      low_active_r        <= 1'b0;
      low_deadline_r      <= '0;
    end else if (in_xfer) begin
      leds_enabled_r      <= leds_enabled_nxt;
      recovery_active_r   <= recovery_active_nxt;
      recovery_deadline_r <= recovery_deadline_nxt;
      low_active_r        <= low_active_nxt;
      low_deadline_r      <= low_deadline_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTHESIS
  // recovery always runs with the drivers off
  a_rec_leds_off: assert property (@(posedge clk) disable iff (!rst_n)
    recovery_active_r |-> !leds_enabled_r)
    else $error("recovery running with LED drivers on");

  // a gcr pulse is reported with catastrophic and the drivers off in the same result
  a_gcr_cat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[3] |-> out_data_r[0] && !out_data_r[1])
    else $error("force_gcr_min without catastrophic and drivers off");

  // catastrophic is never reported with the drivers on
  a_cat_leds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[0] |-> !out_data_r[1])
    else $error("catastrophic reported with LED drivers on");

  // every accepted check leaves a result behind
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("accepted check produced no result");
`endif

endmodule

`default_nettype wire

@@ rtl/core/sus_lane.sv @@
`default_nettype none

module sus_lane (
  input  wire sus_pkg::sample_t  sample,
  input  wire sus_pkg::sample_t  cat_threshold,
  output sus_pkg::lane_res_t     res
);

  // a retest sample strictly above the threshold clears the spike
  always_comb begin
    res.hit    = (sample > cat_threshold);
    res.sample = sample;
  end

endmodule

`default_nettype wire

@@ rtl/core/sus_merge.sv @@
`default_nettype none

module sus_merge #(
  parameter int unsigned LANES = 4
) (
  input  wire sus_pkg::sample_t   reading,
  input  wire sus_pkg::sample_t   cat_threshold,
  input  wire sus_pkg::lane_res_t lane_res [LANES],
  output sus_pkg::sample_t        settled,
  output logic                    cat_now
);

  logic spike;

  // lowest lane that hit wins: scan from the top so it is applied last
  always_comb begin
    spike   = (reading < cat_threshold);
    settled = reading;
    if (spike) begin
      for (int i = LANES - 1; i >= 0; i--) begin
        if (lane_res[i].hit) begin
          settled = lane_res[i].sample;
        end
      end
    end
    cat_now = (settled < cat_threshold);
  end

endmodule

`default_nettype wire
